// ===== hdl/particle_pool_euler_update_assert.svh =====
// assertion macros used by the checker file
`ifndef PARTICLE_POOL_EULER_UPDATE_ASSERT_SVH
`define PARTICLE_POOL_EULER_UPDATE_ASSERT_SVH

// same-cycle implication
`define PPEU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ppeu: property failed");

// next-cycle implication
`define PPEU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ppeu: property failed");

`endif

// ===== hdl/ppeu_pkg.sv =====
package ppeu_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int IDX_W  = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
   localparam int CNT_W  = IDX_W + 1;
   localparam int LIVE_W = 11;
   localparam int DATA_W = 32;
   localparam int LIFE_W = 31;
   localparam int DT_W   = 16;
   localparam int PROD_W = DATA_W + DT_W;

   // 9.81 in q16.16, rounded to nearest
   localparam logic signed [DATA_W-1:0] GRAVITY_Q16 = 32'sd642908;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_TICK = 1'b1;

   typedef struct packed {
      logic signed [DATA_W-1:0] life;
      logic signed [DATA_W-1:0] vel_z;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_x;
   } particle_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] mul_a;
      logic [DT_W-1:0]          mul_b;
      logic signed [DATA_W-1:0] add_a;
      logic signed [DATA_W-1:0] add_b;
      logic                     sub;
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GMUL,
      ST_GSAVE,
      ST_READ,
      ST_LOAD,
      ST_MUL,
      ST_ADD,
      ST_VY,
      ST_LIFE,
      ST_WB
   } state_type;

endpackage

// ===== hdl/ppeu_ram.sv =====
module ppeu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ppeu_alu.sv =====
module ppeu_alu
   import ppeu_pkg::*;
(
   input  logic                     clock,
   input  alu_op_type               op,
   output logic signed [DATA_W-1:0] scaled,
   output logic signed [DATA_W-1:0] sum
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [DT_W:0]     mul_b_s;
   logic signed [DATA_W:0]   wide_sum;

   // signed q16.16 times unsigned q0.16, registered
   assign mul_b_s = $signed({1'b0, op.mul_b});
   assign prod_in = op.mul_a * mul_b_s;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // arithmetic shift by 16 floors toward minus infinity
   assign scaled = prod_ff[PROD_W-1:DT_W];

   // saturating add or subtract
   always_comb begin
      if (op.sub) begin
         wide_sum = {op.add_a[DATA_W-1], op.add_a} - {op.add_b[DATA_W-1], op.add_b};
      end else begin
         wide_sum = {op.add_a[DATA_W-1], op.add_a} + {op.add_b[DATA_W-1], op.add_b};
      end
      if (wide_sum[DATA_W] != wide_sum[DATA_W-1]) begin
         sum = wide_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sum = wide_sum[DATA_W-1:0];
      end
   end

endmodule

// ===== hdl/particle_pool_euler_update.sv =====
// particle pool with explicit euler integration
//
// command channel: a word is taken at a rising edge with start high and busy low.
// req_mode = 0 adds one particle (req_pos_*, req_vel_*, req_life_init), 1 runs one
// tick of req_dt over every live particle. each word gives exactly one response
// word: rsp_valid is high for one cycle with rsp_live_count and rsp_dropped.
// the receiver cannot hold responses off; there is nothing to stall.
//
// an add does not raise busy: the response shows in the next cycle and busy stays
// low, so adds may follow every cycle. a tick raises busy while it runs; with n
// the live count when the tick is taken, a particle that dies hands its slot
// to the last live one, which is visited in its place, so a tick makes exactly n
// visits. each visit is one read of the particle memory, three multiply/add
// pairs and two subtracts on the one shared multiplier and saturating adder,
// then one write if the particle still lives; the response comes with busy falling.
//
// synchronous reset empties the pool and idles the sequencer; the particle
// memory is not cleared, as only slots below the live count are ever read.
module particle_pool_euler_update
   import ppeu_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic signed [DATA_W-1:0] req_pos_x,
   input  logic signed [DATA_W-1:0] req_pos_y,
   input  logic signed [DATA_W-1:0] req_pos_z,
   input  logic signed [DATA_W-1:0] req_vel_x,
   input  logic signed [DATA_W-1:0] req_vel_y,
   input  logic signed [DATA_W-1:0] req_vel_z,
   input  logic [LIFE_W-1:0]        req_life_init,
   input  logic [DT_W-1:0]          req_dt,
   output logic                     rsp_valid,
   output logic [LIVE_W-1:0]        rsp_live_count,
   output logic                     rsp_dropped
);

   // sequencer state
   state_type state_ff, state_in;

   // pool bookkeeping
   logic [CNT_W-1:0] live_ff, live_in;     // live particles between items
   logic [CNT_W-1:0] n_ff, n_in;           // live particles during a tick
   logic [IDX_W-1:0] idx_ff, idx_in;       // slot being written back
   logic [IDX_W-1:0] src_ff, src_in;       // slot being read
   logic [1:0]       step_ff, step_in;     // axis for the multiply/add pairs

   // working copies
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic signed [DATA_W-1:0] grav_ff, grav_in;   // gravity * dt for this tick
   particle_type             ent_ff, ent_in;

   // response word
   logic              rsp_valid_ff, rsp_valid_in;
   logic [LIVE_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_drop_ff, rsp_drop_in;

   // memory and shared unit
   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   particle_type     ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   particle_type     ram_rd_data;
   alu_op_type       alu_op;
   logic signed [DATA_W-1:0] alu_scaled;
   logic signed [DATA_W-1:0] alu_sum;

   // decisions used by the combinational blocks
   logic             accept;
   logic             has_room;
   logic             alive;
   logic             last_slot;
   logic [CNT_W-1:0] idx_next;
   logic [CNT_W-1:0] n_less;

   assign accept    = start && (state_ff == ST_IDLE);
   assign has_room  = (live_ff < CNT_W'(MAX_PARTICLES));
   assign alive     = (ent_ff.life > 0);
   assign idx_next  = {1'b0, idx_ff} + CNT_W'(1);
   assign n_less    = n_ff - CNT_W'(1);
   // the slot under work is the last live one
   assign last_slot = alive ? (idx_next == n_ff) : ({1'b0, idx_ff} == n_less);

   ppeu_ram #(
      .WIDTH ($bits(particle_type)),
      .DEPTH (MAX_PARTICLES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ppeu_alu u_alu (
      .clock  (clock),
      .op     (alu_op),
      .scaled (alu_scaled),
      .sum    (alu_sum)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_mode == MODE_TICK)) begin
               state_in = ST_GMUL;
            end
         end
         ST_GMUL:  state_in = ST_GSAVE;
         ST_GSAVE: state_in = (n_ff == '0) ? ST_IDLE : ST_READ;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = (step_ff == 2'd2) ? ST_VY : ST_MUL;
         ST_VY:    state_in = ST_LIFE;
         ST_LIFE:  state_in = ST_WB;
         ST_WB:    state_in = last_slot ? ST_IDLE : ST_READ;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath control and register next values
   always_comb begin
      live_in      = live_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      src_in       = src_ff;
      step_in      = step_ff;
      dt_in        = dt_ff;
      grav_in      = grav_ff;
      ent_in       = ent_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      rsp_drop_in  = 1'b0;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_data  = ent_ff;
      ram_rd_addr  = src_ff;

      alu_op.mul_a = ent_ff.vel_x;
      alu_op.mul_b = dt_ff;
      alu_op.add_a = ent_ff.pos_x;
      alu_op.add_b = alu_scaled;
      alu_op.sub   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == MODE_ADD) begin
                  rsp_valid_in = 1'b1;
                  if (has_room) begin
                     ram_wr_en         = 1'b1;
                     ram_wr_addr       = live_ff[IDX_W-1:0];
                     ram_wr_data.pos_x = req_pos_x;
                     ram_wr_data.pos_y = req_pos_y;
                     ram_wr_data.pos_z = req_pos_z;
                     ram_wr_data.vel_x = req_vel_x;
                     ram_wr_data.vel_y = req_vel_y;
                     ram_wr_data.vel_z = req_vel_z;
                     ram_wr_data.life  = $signed({1'b0, req_life_init});
                     live_in           = live_ff + CNT_W'(1);
                     rsp_count_in      = LIVE_W'(live_ff + CNT_W'(1));
                  end else begin
                     rsp_drop_in  = 1'b1;
                     rsp_count_in = LIVE_W'(live_ff);
                  end
               end else begin
                  dt_in  = req_dt;
                  n_in   = live_ff;
                  idx_in = '0;
                  src_in = '0;
               end
            end
         end
         ST_GMUL: begin
            alu_op.mul_a = GRAVITY_Q16;
         end
         ST_GSAVE: begin
            grav_in = alu_scaled;
            if (n_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = LIVE_W'(n_ff);
               live_in      = n_ff;
            end
         end
         ST_READ: begin
            // address already on the read port
         end
         ST_LOAD: begin
            ent_in  = ram_rd_data;
            step_in = 2'd0;
         end
         ST_MUL: begin
            case (step_ff)
               2'd1:    alu_op.mul_a = ent_ff.vel_y;
               2'd2:    alu_op.mul_a = ent_ff.vel_z;
               default: alu_op.mul_a = ent_ff.vel_x;
            endcase
         end
         ST_ADD: begin
            case (step_ff)
               2'd1: begin
                  alu_op.add_a = ent_ff.pos_y;
                  ent_in.pos_y = alu_sum;
               end
               2'd2: begin
                  alu_op.add_a = ent_ff.pos_z;
                  ent_in.pos_z = alu_sum;
               end
               default: begin
                  alu_op.add_a = ent_ff.pos_x;
                  ent_in.pos_x = alu_sum;
               end
            endcase
            step_in = step_ff + 2'd1;
         end
         ST_VY: begin
            alu_op.add_a = ent_ff.vel_y;
            alu_op.add_b = grav_ff;
            alu_op.sub   = 1'b1;
            ent_in.vel_y = alu_sum;
         end
         ST_LIFE: begin
            alu_op.add_a = ent_ff.life;
            alu_op.add_b = $signed({{(DATA_W-DT_W){1'b0}}, dt_ff});
            alu_op.sub   = 1'b1;
            ent_in.life  = alu_sum;
         end
         ST_WB: begin
            if (alive) begin
               ram_wr_en = 1'b1;
               if (last_slot) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = LIVE_W'(n_ff);
                  live_in      = n_ff;
               end else begin
                  idx_in = idx_next[IDX_W-1:0];
                  src_in = idx_next[IDX_W-1:0];
               end
            end else begin
               // dead: pull in the last live particle and work it in this slot
               n_in = n_less;
               if (last_slot) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = LIVE_W'(n_less);
                  live_in      = n_less;
               end else begin
                  src_in = n_less[IDX_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      src_ff       <= src_in;
      step_ff      <= step_in;
      dt_ff        <= dt_in;
      grav_ff      <= grav_in;
      ent_ff       <= ent_in;
      rsp_count_ff <= rsp_count_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_live_count = rsp_count_ff;
   assign rsp_dropped    = rsp_drop_ff;

endmodule

// ===== hdl/ppeu_checker.sv =====
`include "particle_pool_euler_update_assert.svh"

module ppeu_checker
   import ppeu_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_mode,
   input logic              rsp_valid,
   input logic [LIVE_W-1:0] rsp_live_count,
   input logic              rsp_dropped
);

   logic add_taken;
   logic tick_taken;

   assign add_taken  = start && !busy && (req_mode == MODE_ADD);
   assign tick_taken = start && !busy && (req_mode == MODE_TICK);

   // an add answers in the very next cycle
   `PPEU_ASSERT_NXT(add_answers_next, clock, reset, add_taken, rsp_valid)
   // a tick always occupies the sequencer
   `PPEU_ASSERT_NXT(tick_goes_busy, clock, reset, tick_taken, busy)
   // the end of a tick carries its response, never a drop
   `PPEU_ASSERT_IMP(tick_ends_with_word, clock, reset, $fell(busy),
                    rsp_valid && !rsp_dropped)
   // a drop only happens with the pool full
   `PPEU_ASSERT_IMP(drop_means_full, clock, reset, rsp_valid && rsp_dropped,
                    rsp_live_count == LIVE_W'(MAX_PARTICLES))

endmodule

bind particle_pool_euler_update ppeu_checker u_checker (.*);

// ===== tb/sv/particle_pool_euler_update_test.sv =====
`timescale 1ns / 100ps

module particle_pool_euler_update_test;
   import ppeu_pkg::*;

   localparam logic [LIFE_W-1:0] LIFE_MAX = '1;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fff_ffff;
   // keeps random ticks short: from this many live particles on only ticks are sent
   localparam int unsigned RANDOM_POOL_CAP = 96;

   // one command word as the sender sees it
   typedef struct {
      logic                     mode;
      logic signed [DATA_W-1:0] pos_x;
      logic signed [DATA_W-1:0] pos_y;
      logic signed [DATA_W-1:0] pos_z;
      logic signed [DATA_W-1:0] vel_x;
      logic signed [DATA_W-1:0] vel_y;
      logic signed [DATA_W-1:0] vel_z;
      logic [LIFE_W-1:0]        life_init;
      logic [DT_W-1:0]          dt;
   } particle_word_type;

   // one response word
   typedef struct {
      logic [LIVE_W-1:0] live_count;
      logic              dropped;
   } pool_status_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic                     req_mode = MODE_ADD;
   logic signed [DATA_W-1:0] req_pos_x = '0;
   logic signed [DATA_W-1:0] req_pos_y = '0;
   logic signed [DATA_W-1:0] req_pos_z = '0;
   logic signed [DATA_W-1:0] req_vel_x = '0;
   logic signed [DATA_W-1:0] req_vel_y = '0;
   logic signed [DATA_W-1:0] req_vel_z = '0;
   logic [LIFE_W-1:0]        req_life_init = '0;
   logic [DT_W-1:0]          req_dt = '0;
   logic                     rsp_valid;
   logic [LIVE_W-1:0]        rsp_live_count;
   logic                     rsp_dropped;

   // remaining life per slot and the live count: only lives decide which
   // particles survive, and positions and velocities never reach the
   // response ports, so they are not tracked
   int          life_left [MAX_PARTICLES];
   int unsigned pool_count = 0;

   // responses still owed by the block, oldest first
   pool_status_type awaited_status [$];

   int unsigned sender_idle_pct = 0;
   int unsigned mismatch_total  = 0;

   particle_pool_euler_update uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_pos_z      (req_pos_z),
      .req_vel_x      (req_vel_x),
      .req_vel_y      (req_vel_y),
      .req_vel_z      (req_vel_z),
      .req_life_init  (req_life_init),
      .req_dt         (req_dt),
      .rsp_valid      (rsp_valid),
      .rsp_live_count (rsp_live_count),
      .rsp_dropped    (rsp_dropped)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // pool model: an add appends a particle if there is room, a tick walks the
   // slots, and a dead particle is replaced by the last live one, which is
   // then processed in the same slot
   function automatic pool_status_type apply_word(particle_word_type w);
      pool_status_type st;
      int unsigned     slot;
      int unsigned     last;
      st.dropped = 1'b0;
      if (w.mode == MODE_ADD) begin
         if (pool_count < MAX_PARTICLES) begin
            life_left[pool_count] = int'(w.life_init);
            pool_count++;
         end else begin
            st.dropped = 1'b1;
         end
      end else begin
         slot = 0;
         last = pool_count;
         while (slot < last) begin
            // stored lives are never negative, so this cannot wrap
            life_left[slot] -= int'(w.dt);
            if (life_left[slot] <= 0) begin
               if (slot != last - 1)
                  life_left[slot] = life_left[last - 1];
               last--;
            end else begin
               slot++;
            end
         end
         pool_count = last;
      end
      st.live_count = pool_count[LIVE_W-1:0];
      return st;
   endfunction

   // fully random word; lives lean short so that particles die often
   function automatic particle_word_type random_word(logic mode);
      particle_word_type w;
      int unsigned       roll;
      w.mode  = mode;
      w.pos_x = $urandom;
      w.pos_y = $urandom;
      w.pos_z = $urandom;
      w.vel_x = $urandom;
      w.vel_y = $urandom;
      w.vel_z = $urandom;
      roll = $urandom_range(99);
      if (roll < 3)
         w.life_init = LIFE_W'($urandom);
      else if (roll < 5)
         w.life_init = LIFE_MAX;
      else if (roll < 10)
         w.life_init = '0;
      else if (roll < 45)
         w.life_init = LIFE_W'($urandom_range(65535, 1));
      else
         w.life_init = LIFE_W'($urandom_range(4 * 65536, 1));
      roll = $urandom_range(99);
      if (roll < 10)
         w.dt = '0;
      else if (roll < 20)
         w.dt = '1;
      else
         w.dt = DT_W'($urandom_range(65535));
      return w;
   endfunction

   function automatic particle_word_type add_word(logic [LIFE_W-1:0] life);
      particle_word_type w;
      w = random_word(MODE_ADD);
      w.life_init = life;
      return w;
   endfunction

   function automatic particle_word_type tick_word(logic [DT_W-1:0] step);
      particle_word_type w;
      w = random_word(MODE_TICK);
      w.dt = step;
      return w;
   endfunction

   // sends one word and books its response once the block has taken it;
   // start is left high so that a following word can go in back to back
   task automatic issue_word(input particle_word_type w);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start         <= 1'b1;
      req_mode      <= w.mode;
      req_pos_x     <= w.pos_x;
      req_pos_y     <= w.pos_y;
      req_pos_z     <= w.pos_z;
      req_vel_x     <= w.vel_x;
      req_vel_y     <= w.vel_y;
      req_vel_z     <= w.vel_z;
      req_life_init <= w.life_init;
      req_dt        <= w.dt;
      // busy read here is its value at the edge, so a low one means taken
      do
         @(posedge clock);
      while (busy);
      awaited_status.push_back(apply_word(w));
   endtask

   // ticks on an empty pool
   task automatic test_empty_tick();
      issue_word(tick_word('0));
      issue_word(tick_word('1));
   endtask

   // field extremes on adds, both dt extremes on ticks
   task automatic test_field_extremes();
      particle_word_type w;
      w = add_word(LIFE_MAX);
      w.pos_x = Q_MIN;
      w.pos_y = Q_MIN;
      w.pos_z = Q_MIN;
      w.vel_x = Q_MAX;
      w.vel_y = Q_MAX;
      w.vel_z = Q_MAX;
      issue_word(w);
      w = add_word(LIFE_W'(1));
      w.pos_x = Q_MAX;
      w.pos_y = Q_MAX;
      w.pos_z = Q_MAX;
      w.vel_x = Q_MIN;
      w.vel_y = Q_MIN;
      w.vel_z = Q_MIN;
      issue_word(w);
      issue_word(add_word(LIFE_W'(65535)));
      // the short one dies, its replacement reaches exactly zero and goes too
      issue_word(tick_word('1));
      issue_word(tick_word('0));
   endtask

   // a particle born with no life, and one that runs down to exactly zero
   task automatic test_zero_life();
      issue_word(add_word('0));
      issue_word(add_word(LIFE_W'(5)));
      issue_word(tick_word('0));
      issue_word(add_word(LIFE_W'(3)));
      issue_word(tick_word(DT_W'(3)));
   endtask

   // the last slot dies and the walk stops there
   task automatic test_last_slot();
      issue_word(add_word(LIFE_W'(200000)));
      issue_word(add_word(LIFE_W'(1)));
      issue_word(tick_word(DT_W'(1)));
   endtask

   // fill the pool, overflow it, tick it full, then drain the short lives
   task automatic test_pool_full();
      while (pool_count < MAX_PARTICLES)
         issue_word(add_word(LIFE_W'($urandom_range(131070, 1))));
      issue_word(random_word(MODE_ADD));
      issue_word(random_word(MODE_ADD));
      issue_word(tick_word('0));
      repeat (3)
         issue_word(tick_word('1));
   endtask

   // mixed adds and ticks; ticks are forced once the pool holds the cap
   task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned words);
      sender_idle_pct = idle_pct;
      repeat (words) begin
         if (pool_count < RANDOM_POOL_CAP && $urandom_range(99) < 60)
            issue_word(random_word(MODE_ADD));
         else
            issue_word(random_word(MODE_TICK));
      end
   endtask

   // response checker: the receiver cannot stall, so every strobe is taken
   always @(posedge clock) begin
      pool_status_type due;
      if (!reset && rsp_valid) begin
         if (awaited_status.size() == 0) begin
            $error("unexpected response: live_count %0d dropped %0b",
                   rsp_live_count, rsp_dropped);
            mismatch_total++;
         end else begin
            due = awaited_status.pop_front();
            if (rsp_live_count !== due.live_count) begin
               $error("live_count: expected %0d, actual %0d", due.live_count, rsp_live_count);
               mismatch_total++;
            end
            if (rsp_dropped !== due.dropped) begin
               $error("dropped: expected %0b, actual %0b", due.dropped, rsp_dropped);
               mismatch_total++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_tick();
      test_field_extremes();
      test_zero_life();
      test_last_slot();
      test_pool_full();
      // no idling, sender mostly idle, sender idle a third of the time
      test_random_traffic(0, 97);
      test_random_traffic(87, 97);
      test_random_traffic(32, 96);
      start <= 1'b0;
      while (awaited_status.size() != 0)
         @(posedge clock);
      // room for a stray response after the last one
      repeat (32) @(posedge clock);
      if (mismatch_total == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // hang guard, well beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ppeu_pkg.sv
hdl/ppeu_ram.sv
hdl/ppeu_alu.sv
hdl/particle_pool_euler_update.sv
hdl/ppeu_checker.sv
tb/sv/particle_pool_euler_update_test.sv
